>>> rtl/core/stack_with_min_max_mean_macros.svh
// ----------------------------------------------------------------------------
// Stack assertion macros
// Shared property shorthands for the stack checker.
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_MIN_MAX_MEAN_MACROS_SVH
`define STACK_WITH_MIN_MAX_MEAN_MACROS_SVH

// check cons in the same cycle as ante
`define SMMM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define SMMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/smmm_pkg.sv
// ----------------------------------------------------------------------------
// Stack package
// Request and status codes shared by the stack and its checker.
// ----------------------------------------------------------------------------
package smmm_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    ACT_PUSH = 3'd0,
    ACT_POP  = 3'd1,
    ACT_PEEK = 3'd2,
    ACT_MAX  = 3'd3,
    ACT_MIN  = 3'd4,
    ACT_MEAN = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

>>> rtl/core/stack_with_min_max_mean.sv
// ----------------------------------------------------------------------------
// LIFO stack with min, max and mean
// Signed 32-bit stack in one synchronous RAM; queries scan the stored entries.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  request   in_valid_i/in_ready_o, action_i,          in
//            push_value_i
//  result    out_valid_o/out_ready_i, result_value_o,  out
//            status_o
//
//  Push, errors and unused codes go from IDLE to DONE; pop and peek pass through READ.
//  Max and min scan the entries, one RAM read port scanning one entry a cycle.
//  Mean: the scan is followed by a radix-2 divider, one quotient bit a cycle,
//  then by a SIGN state that restores the sign of the quotient.
//  Reset empties the stack at once; RAM contents are not cleared.
//  One result may wait in the output stage; a second finished one holds in DONE.
module stack_with_min_max_mean
  import smmm_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               action_i,
  input  logic signed [DATA_W-1:0] push_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] result_value_o,
  output logic [1:0]               status_o
);

  localparam int unsigned CntW    = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SumW    = DATA_W + CntW;
  localparam int unsigned DivCntW = $clog2(SumW);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_SCAN = 6'b000100,
    S_DIV  = 6'b001000,
    S_SIGN = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  state_e              state_q, state_d;
  action_e             act_q, act_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     issue_q, issue_d;
  logic                dvld_q, dvld_d;
  logic                first_q, first_d;
  logic [DATA_W-1:0]   acc_q, acc_d;
  logic [SumW-1:0]     sum_q, sum_d;
  logic [SumW-1:0]     quot_q, quot_d;
  logic [CntW-1:0]     rem_q, rem_d;
  logic [DivCntW-1:0]  dcnt_q, dcnt_d;
  logic                neg_q, neg_d;
  logic [DATA_W-1:0]   res_val_q, res_val_d;
  status_e             res_st_q, res_st_d;
  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   out_val_q, out_val_d;
  status_e             out_st_q, out_st_d;

  logic                in_beat;
  logic                wr_en, rd_en;
  logic [AddrW-1:0]    wr_addr, rd_addr;
  logic [CntW-1:0]     top_idx;
  logic                is_empty, is_full;
  logic                take_new;
  logic [CntW:0]       div_sh;
  logic [CntW+1:0]     div_trial;
  logic                div_ge;
  logic [SumW-1:0]     sum_ext;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  assign top_idx    = count_q - CntW'(1);
  assign is_empty   = (count_q == '0);
  assign is_full    = (count_q == CntW'(STACK_DEPTH));
  assign take_new   = !out_valid_q || out_ready_i;
  assign sum_ext    = {{CntW{rdata_q[DATA_W-1]}}, rdata_q};
  assign div_sh     = {rem_q, quot_q[SumW-1]};
  assign div_trial  = {1'b0, div_sh} - {2'b00, count_q};
  assign div_ge     = !div_trial[CntW+1];

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    count_d     = count_q;
    issue_d     = issue_q;
    dvld_d      = 1'b0;
    first_d     = first_q;
    acc_d       = acc_q;
    sum_d       = sum_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    neg_d       = neg_q;
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_val_d   = out_val_q;
    out_st_d    = out_st_q;
    wr_en       = 1'b0;
    wr_addr     = count_q[AddrW-1:0];
    rd_en       = 1'b0;
    rd_addr     = top_idx[AddrW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          act_d     = action_e'(action_i);
          res_val_d = '0;
          res_st_d  = ST_OK;
          state_d   = S_DONE;
          unique case (action_e'(action_i)) inside
            ACT_PUSH: begin
              if (is_full) begin
                res_st_d = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CntW'(1);
              end
            end
            ACT_POP, ACT_PEEK: begin
              if (is_empty) begin
                res_st_d = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                state_d = S_READ;
                if (action_e'(action_i) == ACT_POP) begin
                  count_d = top_idx;
                end
              end
            end
            ACT_MAX, ACT_MIN, ACT_MEAN: begin
              if (is_empty) begin
                res_st_d = ST_EMPTY;
              end else begin
                issue_d = '0;
                first_d = 1'b1;
                sum_d   = '0;
                state_d = S_SCAN;
              end
            end
            default: begin
              res_st_d = ST_OK;
            end
          endcase
        end
      end

      S_READ: begin
        res_val_d = rdata_q;
        state_d   = S_DONE;
      end

      S_SCAN: begin
        rd_addr = issue_q[AddrW-1:0];
        if (issue_q != count_q) begin
          rd_en   = 1'b1;
          dvld_d  = 1'b1;
          issue_d = issue_q + CntW'(1);
        end
        if (dvld_q) begin
          first_d = 1'b0;
          sum_d   = sum_q + sum_ext;
          if (first_q ||
              ((act_q == ACT_MAX) && ($signed(rdata_q) > $signed(acc_q))) ||
              ((act_q == ACT_MIN) && ($signed(rdata_q) < $signed(acc_q)))) begin
            acc_d = rdata_q;
          end
        end
        if ((issue_q == count_q) && !dvld_q) begin
          if (act_q == ACT_MEAN) begin
            neg_d   = sum_q[SumW-1];
            quot_d  = sum_q[SumW-1] ? (SumW'(0) - sum_q) : sum_q;
            rem_d   = '0;
            dcnt_d  = '0;
            state_d = S_DIV;
          end else begin
            res_val_d = acc_q;
            state_d   = S_DONE;
          end
        end
      end

      S_DIV: begin
        rem_d  = div_ge ? div_trial[CntW-1:0] : div_sh[CntW-1:0];
        quot_d = {quot_q[SumW-2:0], div_ge};
        dcnt_d = dcnt_q + DivCntW'(1);
        if (dcnt_q == DivCntW'(SumW - 1)) begin
          state_d = S_SIGN;
        end
      end

      S_SIGN: begin
        res_val_d = neg_q ? (DATA_W'(0) - quot_q[DATA_W-1:0]) : quot_q[DATA_W-1:0];
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (take_new) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= push_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      dvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dvld_q      <= dvld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    issue_q   <= issue_d;
    first_q   <= first_d;
    acc_q     <= acc_d;
    sum_q     <= sum_d;
    quot_q    <= quot_d;
    rem_q     <= rem_d;
    dcnt_q    <= dcnt_d;
    neg_q     <= neg_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    out_val_q <= out_val_d;
    out_st_q  <= out_st_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_val_q;
  assign status_o       = out_st_q;

endmodule

>>> rtl/core/smmm_checker.sv
// ----------------------------------------------------------------------------
// Stack port checker
// Tracks stack occupancy from the request beats and checks push results, empty statuses and the handshakes.
// ----------------------------------------------------------------------------
`include "stack_with_min_max_mean_macros.svh"

module smmm_checker
  import smmm_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 256
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic [2:0]               action_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [DATA_W-1:0] result_value_o,
  input logic [1:0]               status_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  logic            in_beat;
  logic            out_fresh;
  logic            prev_valid_q, prev_ready_q;
  logic [CntW-1:0] shd_cnt_q;
  logic [CntW-1:0] pre_cnt_q;
  logic [2:0]      act_q;

  assign in_beat   = in_valid_i && in_ready_o;
  assign out_fresh = out_valid_o && !(prev_valid_q && !prev_ready_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_valid_q <= 1'b0;
      prev_ready_q <= 1'b0;
      shd_cnt_q    <= '0;
      pre_cnt_q    <= '0;
      act_q        <= ACT_PUSH;
    end else begin
      prev_valid_q <= out_valid_o;
      prev_ready_q <= out_ready_i;
      if (in_beat) begin
        pre_cnt_q <= shd_cnt_q;
        act_q     <= action_i;
        if ((action_i == ACT_PUSH) && (shd_cnt_q != CntW'(STACK_DEPTH))) begin
          shd_cnt_q <= shd_cnt_q + CntW'(1);
        end else if ((action_i == ACT_POP) && (shd_cnt_q != '0)) begin
          shd_cnt_q <= shd_cnt_q - CntW'(1);
        end
      end
    end
  end

  `SMMM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(result_value_o) && $stable(status_o), "result beat changed while stalled")
  `SMMM_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_beat, !in_ready_o, "request taken while busy")
  `SMMM_ASSERT_IMPLY(a_push_result, clk_i, rst_ni, out_fresh && (act_q == ACT_PUSH), (result_value_o == '0) && ((status_o == ST_FULL) == (pre_cnt_q == CntW'(STACK_DEPTH))), "push result mismatch")
  `SMMM_ASSERT_IMPLY(a_empty_status, clk_i, rst_ni, out_fresh && (status_o == ST_EMPTY), (pre_cnt_q == '0) && (act_q != ACT_PUSH), "empty status on occupied stack")

endmodule

bind stack_with_min_max_mean smmm_checker #(.STACK_DEPTH(STACK_DEPTH)) u_smmm_checker (.*);

>>> bench/tb_stack_with_min_max_mean.sv
// ----------------------------------------------------------------------------
// Stack with min, max and mean: self-checking bench
// Feeds push, pop, peek and query requests through the valid/ready request
// channel and compares each result beat against a behavioral stack model.
// Runs a short directed table, then random traffic: shallow mixed stacks,
// fill-to-full and drain-to-empty runs. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_stack_with_min_max_mean;
  timeunit 1ns;
  timeprecision 1ps;

  import smmm_pkg::*;

  localparam int unsigned DEPTH       = 256;
  localparam int          HALF_PERIOD = 6;
  localparam int          RESET_CYCLES = 12;
  localparam int          N_ITEMS     = 1500;
  localparam int          MAX_LAT     = DEPTH + 41 + 16;
  localparam int          LONG_HOLD   = 800;
  localparam int          CYCLE_LIMIT = 2_000_000;

  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;

  typedef struct {
    logic [2:0]         act;
    logic signed [31:0] val;
    bit                 typed;
    logic signed [31:0] exp_val;
    logic [1:0]         exp_st;
  } request_t;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         status;
  } result_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic [2:0]         action_i     = '0;
  logic signed [31:0] push_value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic signed [31:0] result_value_o;
  logic [1:0]         status_o;

  logic               cur_typed   = 1'b0;
  logic signed [31:0] cur_exp_val = '0;
  logic [1:0]         cur_exp_st  = '0;

  logic signed [31:0] mirror_stack [DEPTH];
  int unsigned        mirror_count = 0;

  request_t directed_q[$];
  result_t  expected_q[$];

  int cycle_cnt    = 0;
  int err_cnt      = 0;
  int sent_cnt     = 0;
  int result_cnt   = 0;
  int burst_left   = 1;
  int gen_depth    = 0;
  int fill_cnt     = 0;
  int push_cnt     = 0;
  int pop_cnt      = 0;
  int query_cnt    = 0;
  int full_cnt     = 0;
  int empty_cnt    = 0;
  int spare_cnt    = 0;
  int peak_depth   = 0;

  stack_with_min_max_mean #(
    .STACK_DEPTH(DEPTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .push_value_i  (push_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_value_o(result_value_o),
    .status_o      (status_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic void evaluate_request(input logic [2:0] act,
                                           input logic signed [31:0] pv,
                                           output logic signed [31:0] val,
                                           output logic [1:0] st);
    longint total;
    logic signed [31:0] pick;
    val   = '0;
    st    = ST_OK;
    total = 0;
    case (act) inside
      ACT_PUSH: begin
        if (mirror_count >= DEPTH) begin
          st = ST_FULL;
        end else begin
          mirror_stack[mirror_count] = pv;
          mirror_count++;
        end
      end
      ACT_POP, ACT_PEEK, ACT_MAX, ACT_MIN, ACT_MEAN: begin
        if (mirror_count == 0) begin
          st = ST_EMPTY;
        end else begin
          case (act) inside
            ACT_POP: begin
              mirror_count--;
              val = mirror_stack[mirror_count];
            end
            ACT_PEEK: val = mirror_stack[mirror_count-1];
            ACT_MAX, ACT_MIN: begin
              pick = mirror_stack[0];
              for (int i = 1; i < mirror_count; i++) begin
                if (act == ACT_MAX ? mirror_stack[i] > pick : mirror_stack[i] < pick)
                  pick = mirror_stack[i];
              end
              val = pick;
            end
            default: begin
              for (int i = 0; i < mirror_count; i++) total += longint'(mirror_stack[i]);
              total = total / longint'(mirror_count);
              val = total[31:0];
            end
          endcase
        end
      end
      default: ;
    endcase
  endfunction

  // scoreboard: predict on request beat, compare on result beat
  always @(posedge clk_i) begin
    logic signed [31:0] pv;
    logic [1:0]         ps;
    result_t            want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        evaluate_request(action_i, push_value_i, pv, ps);
        if (cur_typed) begin
          want.value  = cur_exp_val;
          want.status = cur_exp_st;
        end else begin
          want.value  = pv;
          want.status = ps;
        end
        expected_q.push_back(want);
        case (action_i) inside
          ACT_PUSH: push_cnt++;
          ACT_POP:  pop_cnt++;
          ACT_SPARE6, ACT_SPARE7: spare_cnt++;
          default:  query_cnt++;
        endcase
        if (ps == ST_FULL) full_cnt++;
        if (ps == ST_EMPTY) empty_cnt++;
        if (mirror_count > peak_depth) peak_depth = mirror_count;
      end
      if (out_valid_o && out_ready_i) begin
        result_cnt++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat, value %h status %0d",
                   $time, result_value_o, status_o);
          err_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (result_value_o !== want.value) begin
            $display("%0t: result %0d value expected %h actual %h",
                     $time, result_cnt, want.value, result_value_o);
            err_cnt++;
          end
          if (status_o !== want.status) begin
            $display("%0t: result %0d status expected %0d actual %0d",
                     $time, result_cnt, want.status, status_o);
            err_cnt++;
          end
        end
      end
    end
  end

  // result side: random ready modes, plus one long hold-off
  initial begin
    int  hold_left;
    int  mode_left;
    int  rx_mode;
    int  pat_idx;
    bit  long_done;
    logic [31:0] stall_pattern;
    hold_left = 0;
    mode_left = 0;
    rx_mode   = 0;
    pat_idx   = 0;
    long_done = 1'b0;
    stall_pattern = '1;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (!long_done && result_cnt >= 300) begin
        long_done = 1'b1;
        hold_left = LONG_HOLD;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode       = $urandom_range(0, 3);
          mode_left     = $urandom_range(32, 256);
          stall_pattern = $urandom | 32'h1;
        end
        mode_left--;
        case (rx_mode)
          0: out_ready_i <= 1'b1;
          1: begin
            out_ready_i <= stall_pattern[pat_idx];
            pat_idx = (pat_idx + 1) % 32;
          end
          2: out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void add_row(logic [2:0] act, logic signed [31:0] val,
                                  bit typed = 1'b0, logic signed [31:0] ev = '0,
                                  logic [1:0] es = ST_OK);
    request_t r;
    r.act     = act;
    r.val     = val;
    r.typed   = typed;
    r.exp_val = ev;
    r.exp_st  = es;
    directed_q.push_back(r);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 1) ? 32'sh0 : -32'sd1;
      3, 4: return int'($urandom_range(0, 200)) - 100;
      default: return $urandom;
    endcase
  endfunction

  task automatic offer(input request_t r);
    int gap;
    in_valid_i   <= 1'b1;
    action_i     <= r.act;
    push_value_i <= r.val;
    cur_typed    <= r.typed;
    cur_exp_val  <= r.exp_val;
    cur_exp_st   <= r.exp_st;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_cnt++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic issue(input logic [2:0] act);
    request_t r;
    r.act     = act;
    r.val     = pick_value();
    r.typed   = 1'b0;
    r.exp_val = '0;
    r.exp_st  = ST_OK;
    if (act == ACT_PUSH && gen_depth < DEPTH) gen_depth++;
    if (act == ACT_POP && gen_depth > 0) gen_depth--;
    offer(r);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
  endtask

  task automatic mixed_run(input int n);
    int push_pct;
    int r;
    repeat (n) begin
      push_pct = (gen_depth < 4) ? 60 : (gen_depth > 40) ? 25 : 45;
      r = $urandom_range(0, 99);
      if (r < push_pct) begin
        issue(ACT_PUSH);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) issue(ACT_POP);
        else if (r < 50) issue(ACT_PEEK);
        else if (r < 65) issue(ACT_MAX);
        else if (r < 80) issue(ACT_MIN);
        else if (r < 97) issue(ACT_MEAN);
        else issue($urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7);
      end
    end
  endtask

  task automatic fill_run();
    int floor_depth;
    fill_cnt++;
    while (gen_depth < DEPTH) issue(ACT_PUSH);
    repeat ($urandom_range(1, 3)) issue(ACT_PUSH);
    issue(ACT_MAX);
    issue(ACT_MIN);
    issue(ACT_MEAN);
    issue(ACT_PEEK);
    floor_depth = $urandom_range(0, 24);
    while (gen_depth > floor_depth) begin
      if ($urandom_range(0, 31) == 0) issue(ACT_PEEK);
      else issue(ACT_POP);
    end
  endtask

  task automatic drain_run();
    while (gen_depth > 0) issue(ACT_POP);
    repeat ($urandom_range(1, 4)) issue(3'($urandom_range(1, 5)));
  endtask

  initial begin
    int r;
    add_row(ACT_POP,    32'sd0,          1'b1, 32'sd0,          ST_EMPTY);
    add_row(ACT_PEEK,   32'sd0,          1'b1, 32'sd0,          ST_EMPTY);
    add_row(ACT_MAX,    32'sh7fffffff,   1'b1, 32'sd0,          ST_EMPTY);
    add_row(ACT_MIN,    -32'sd1,         1'b1, 32'sd0,          ST_EMPTY);
    add_row(ACT_MEAN,   32'sd0,          1'b1, 32'sd0,          ST_EMPTY);
    add_row(ACT_SPARE6, 32'sh12345678,   1'b1, 32'sd0,          ST_OK);
    add_row(ACT_SPARE7, -32'sd1,         1'b1, 32'sd0,          ST_OK);
    add_row(ACT_PUSH,   32'sh7fffffff,   1'b1, 32'sd0,          ST_OK);
    add_row(ACT_PUSH,   32'sh80000000,   1'b1, 32'sd0,          ST_OK);
    add_row(ACT_MAX,    32'sd0,          1'b1, 32'sh7fffffff,   ST_OK);
    add_row(ACT_MIN,    32'sd0,          1'b1, 32'sh80000000,   ST_OK);
    add_row(ACT_MEAN,   32'sd0);
    add_row(ACT_PEEK,   32'sd0,          1'b1, 32'sh80000000,   ST_OK);
    add_row(ACT_PUSH,   -32'sd1);
    add_row(ACT_PUSH,   -32'sd2);
    add_row(ACT_MEAN,   32'sd0);
    add_row(ACT_MAX,    32'sd0);
    add_row(ACT_MIN,    32'sd0);
    add_row(ACT_POP,    32'sd0,          1'b1, -32'sd2,         ST_OK);
    add_row(ACT_POP,    32'sd0,          1'b1, -32'sd1,         ST_OK);
    add_row(ACT_MEAN,   32'sd0);
    add_row(ACT_POP,    32'sd0,          1'b1, 32'sh80000000,   ST_OK);
    add_row(ACT_POP,    32'sd0,          1'b1, 32'sh7fffffff,   ST_OK);
    add_row(ACT_PUSH,   32'sd7);
    add_row(ACT_MEAN,   32'sd0,          1'b1, 32'sd7,          ST_OK);
    add_row(ACT_POP,    32'sd0,          1'b1, 32'sd7,          ST_OK);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) offer(directed_q[i]);
    drain_results();

    fill_run();
    while (sent_cnt < N_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 3 && fill_cnt < 3 && sent_cnt + 600 < N_ITEMS) fill_run();
      else if (r < 15) drain_run();
      else mixed_run($urandom_range(20, 60));
      if ($urandom_range(0, 7) == 0) drain_results();
    end

    drain_results();
    repeat (MAX_LAT) @(posedge clk_i);

    $display("Sent %0d requests: %0d pushes, %0d pops, %0d peeks/queries, %0d spare codes",
             sent_cnt, push_cnt, pop_cnt, query_cnt, spare_cnt);
    $display("Full rejects %0d, empty rejects %0d, fill runs %0d, deepest stack %0d",
             full_cnt, empty_cnt, fill_cnt, peak_depth);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
